@@ src/rqs_pkg.sv @@
// Package with types and constants for the ready queue scheduler select unit.
package rqs_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_MIN_PRIO = 3'd2;
    localparam logic [2:0] CMD_MIN_BURST = 3'd3;
    localparam logic [2:0] CMD_MIN_QUANTUM = 3'd4;
    localparam logic [2:0] CMD_AGE = 3'd5;
    localparam logic [2:0] CMD_CLEAR_Q = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] task_id;
        logic [7:0]  prio_in;
        logic [15:0] burst_in;
        logic [15:0] quantum_in;
        logic [15:0] wait_in;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] sel_id;
        logic [7:0]  sel_prio;
        logic [15:0] sel_burst;
        logic [15:0] sel_quantum;
        logic [15:0] sel_wait;
        logic [4:0]  occupancy;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] quantum;
        logic [15:0] waitt;
    } task_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        shift;    // move every task one cell toward the head
        logic        load;     // write a task into the selected cell
    } cell_ctrl_t;

endpackage

@@ src/ready_queue_scheduler_select_unit.sv @@
// Top level of the ready queue scheduler select unit: sequencer and cell chain.
// The table is a row of ENTRIES cells with cell 0 at the head; the live tasks sit in
// cells 0 to occupancy - 1 in arrival order. A push writes the cell at the current
// occupancy; the scan state writes it and the done state loads its result. Delete, select,
// aging and quantum clear walk the live tasks once: every cycle the chain moves one cell
// toward the head, and the task leaving the head is written back behind the tasks not
// yet visited and behind the ones already written back, modified on the way (aged,
// quantum cleared) or left out on a delete, which compacts the table in order. Such a
// command walks the live tasks, notices the end of the walk in the scan state and loads
// the result in the done state. The walk length is set by the single head port of the
// chain. The result sits in an output register and the next beat is taken in the cycle
// in which that result is delivered, so a command is taken only after the previous
// result has been delivered.
module ready_queue_scheduler_select_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rqs_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rqs_pkg::out_beat_t out_data
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t state_reg;
    rqs_pkg::in_beat_t cmd_reg;
    logic [rqs_pkg::CNT_W-1:0] fill_reg;
    logic [rqs_pkg::CNT_W-1:0] kept_reg;
    logic [rqs_pkg::CNT_W-1:0] step_reg;
    logic have_best_reg;
    logic full_reg;
    rqs_pkg::task_t best_reg;
    logic out_valid_reg;
    rqs_pkg::out_beat_t out_reg;

    rqs_pkg::cell_ctrl_t ctrl;
    rqs_pkg::task_t cells [rqs_pkg::ENTRIES];
    rqs_pkg::task_t head;
    rqs_pkg::task_t ring_in;
    rqs_pkg::task_t push_task;
    rqs_pkg::task_t write_task;
    logic live;
    logic drop;
    logic [rqs_pkg::CNT_W-1:0] wr_pos;
    logic [15:0] key_head;
    logic [15:0] key_best;

    // The head cell is the live task at this step when the step is below the count.
    assign head = cells[0];
    assign live = step_reg < fill_reg;

    always_comb
    begin
        case (cmd_reg.command)
            rqs_pkg::CMD_MIN_PRIO:
            begin
                key_head = {8'd0, head.prio};
                key_best = {8'd0, best_reg.prio};
            end
            rqs_pkg::CMD_MIN_BURST:
            begin
                key_head = head.burst;
                key_best = best_reg.burst;
            end
            default:
            begin
                key_head = head.quantum;
                key_best = best_reg.quantum;
            end
        endcase
    end

    always_comb
    begin
        ring_in = head;
        if (live && cmd_reg.command == rqs_pkg::CMD_AGE && head.id != cmd_reg.task_id
            && head.waitt != 16'hFFFF)
        begin
            ring_in.waitt = head.waitt + 16'd1;
        end
        if (live && cmd_reg.command == rqs_pkg::CMD_CLEAR_Q)
        begin
            ring_in.quantum = 16'd0;
        end
    end

    assign push_task = '{id: cmd_reg.task_id, prio: cmd_reg.prio_in,
                         burst: cmd_reg.burst_in, quantum: cmd_reg.quantum_in,
                         waitt: cmd_reg.wait_in};

    assign drop = live && cmd_reg.command == rqs_pkg::CMD_DELETE
                  && head.id == cmd_reg.task_id;

    always_comb
    begin
        ctrl = '0;
        if (state_reg == S_SCAN)
        begin
            if (cmd_reg.command == rqs_pkg::CMD_PUSH)
            begin
                ctrl.load = fill_reg != rqs_pkg::CNT_W'(rqs_pkg::ENTRIES);
            end
            else
            begin
                ctrl.shift = live;
                ctrl.load = live && !drop;
            end
        end
    end

    // During a walk the tasks not yet visited occupy the cells below occupancy - step,
    // and the tasks already written back follow them; the next one goes right behind.
    always_comb
    begin
        if (cmd_reg.command == rqs_pkg::CMD_PUSH)
        begin
            wr_pos = fill_reg;
            write_task = push_task;
        end
        else
        begin
            wr_pos = fill_reg - step_reg + kept_reg - 1'b1;
            write_task = ring_in;
        end
    end

    genvar g;
    generate
        for (g = 0; g < rqs_pkg::ENTRIES; g++)
        begin : g_cell
            rqs_pkg::task_t nxt;
            if (g == rqs_pkg::ENTRIES - 1)
            begin : g_last
                assign nxt = cells[g];
            end
            else
            begin : g_mid
                assign nxt = cells[g+1];
            end
            rqs_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .from_next  (nxt),
                .load_task  (write_task),
                .write_here (wr_pos == rqs_pkg::CNT_W'(g)),
                .held       (cells[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            out_valid_reg <= 1'b0;
            step_reg <= '0;
            kept_reg <= '0;
            have_best_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg <= in_data;
                        step_reg <= '0;
                        kept_reg <= '0;
                        have_best_reg <= 1'b0;
                        full_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cmd_reg.command == rqs_pkg::CMD_PUSH)
                    begin
                        if (ctrl.load)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        full_reg <= !ctrl.load;
                        state_reg <= S_DONE;
                    end
                    else if (live)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (!drop)
                        begin
                            kept_reg <= kept_reg + 1'b1;
                        end
                        if (!have_best_reg || key_best > key_head)
                        begin
                            have_best_reg <= 1'b1;
                            best_reg <= head;
                        end
                    end
                    else
                    begin
                        if (cmd_reg.command == rqs_pkg::CMD_DELETE)
                        begin
                            fill_reg <= kept_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '0;
                        out_reg.occupancy <= 5'(fill_reg);
                        if (cmd_reg.command == rqs_pkg::CMD_PUSH && full_reg)
                        begin
                            out_reg.status <= rqs_pkg::ST_FULL;
                        end
                        if (cmd_reg.command == rqs_pkg::CMD_MIN_PRIO
                            || cmd_reg.command == rqs_pkg::CMD_MIN_BURST
                            || cmd_reg.command == rqs_pkg::CMD_MIN_QUANTUM)
                        begin
                            if (!have_best_reg)
                            begin
                                out_reg.status <= rqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_reg.sel_id <= best_reg.id;
                                out_reg.sel_prio <= best_reg.prio;
                                out_reg.sel_burst <= best_reg.burst;
                                out_reg.sel_quantum <= best_reg.quantum;
                                out_reg.sel_wait <= best_reg.waitt;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // Occupancy never exceeds the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= rqs_pkg::CNT_W'(rqs_pkg::ENTRIES))
        else $error("occupancy above depth");

    // No new beat is taken while a command is in progress.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while busy");

    // A push that fits grows the table by exactly one.
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load && cmd_reg.command == rqs_pkg::CMD_PUSH)
        |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("push count slip");
endmodule

@@ src/rqs_cell.sv @@
// One cell of the task chain: holds one task and passes it to its neighbor.
module rqs_cell (
    input  logic                clk,
    input  rqs_pkg::cell_ctrl_t ctrl,
    input  rqs_pkg::task_t      from_next,
    input  rqs_pkg::task_t      load_task,
    input  logic                write_here,
    output rqs_pkg::task_t      held
);
    rqs_pkg::task_t task_reg;
    rqs_pkg::task_t task_next;

    // A write into this cell takes precedence over the shift.
    always_comb
    begin
        task_next = task_reg;
        if (ctrl.load && write_here)
        begin
            task_next = load_task;
        end
        else if (ctrl.shift)
        begin
            task_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
    end

    assign held = task_reg;
endmodule
